FILE: src/gafd_pkg.sv
`default_nettype none

package gafd_pkg;

	localparam int PIX_W          = 8;
	localparam int FACTOR_W       = 8;
	localparam int COORD_W        = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int DEF_MAX_FACTOR = 255;
	localparam int Q_DEPTH        = 4;
	localparam int Q_PTR_W        = $clog2(Q_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FACTOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEFT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [FACTOR_W-1:0] skip_cols;
		logic [FACTOR_W-1:0] skip_rows;
		logic [COORD_W-1:0]  fw;
		logic [COORD_W-1:0]  fh;
		logic [COORD_W-1:0]  left;
		logic [COORD_W-1:0]  top;
		logic [COORD_W-1:0]  ow;
		logic [COORD_W-1:0]  oh;
	} frame_desc_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
	} out_item_t;

endpackage

`default_nettype wire

FILE: src/gafd_setup.sv
`default_nettype none

module gafd_setup #(
	parameter int MAX_FACTOR = gafd_pkg::DEF_MAX_FACTOR
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gafd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gafd_pkg::COORD_W-1:0]     cfg_data,
	output logic                             busy,
	output gafd_pkg::frame_desc_t            desc
);
	import gafd_pkg::*;

	localparam int STEP_W = $clog2(COORD_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_LEFT,
		S_TOP,
		S_WIDTH,
		S_HEIGHT
	} state_t;

	state_t              state_q;
	logic [FACTOR_W-1:0] sf_q;
	logic [COORD_W-1:0]  left_q;
	logic [COORD_W-1:0]  top_q;
	logic [COORD_W-1:0]  fw_q;
	logic [COORD_W-1:0]  fh_q;
	logic [COORD_W-1:0]  sw_q;
	logic [COORD_W-1:0]  sh_q;
	logic [COORD_W-1:0]  acc_q;
	logic [FACTOR_W-1:0] rem_q;
	logic [STEP_W-1:0]   step_q;
	frame_desc_t         desc_q;

	logic [COORD_W-1:0]  min_dim;
	logic [FACTOR_W-1:0] f_clamp;
	logic [FACTOR_W:0]   r_ext;
	logic                ge;
	logic [FACTOR_W-1:0] rem_n;
	logic [COORD_W-1:0]  acc_n;
	logic [COORD_W-1:0]  ceil_n;
	logic [FACTOR_W-1:0] skip_n;
	logic                last_step;
	logic [COORD_W-1:0]  w_dvd;
	logic [COORD_W-1:0]  h_dvd;

	// The factor in use is clamped to one, to the maximum and to the smaller screen side.
	always_comb begin
		min_dim = (sw_q < sh_q) ? sw_q : sh_q;
		if (min_dim == '0) begin
			min_dim = COORD_W'(1);
		end
		f_clamp = (sf_q == '0) ? FACTOR_W'(1) : sf_q;
		if (f_clamp > FACTOR_W'(MAX_FACTOR)) begin
			f_clamp = FACTOR_W'(MAX_FACTOR);
		end
		if ({{(COORD_W-FACTOR_W){1'b0}}, f_clamp} > min_dim) begin
			f_clamp = min_dim[FACTOR_W-1:0];
		end
	end

	// One restoring division step per cycle, unless a configuration write restarts set-up.
	always_comb begin
		r_ext     = {rem_q, acc_q[COORD_W-1]};
		ge        = r_ext >= {1'b0, desc_q.factor};
		rem_n     = ge ? FACTOR_W'(r_ext - {1'b0, desc_q.factor}) : r_ext[FACTOR_W-1:0];
		acc_n     = {acc_q[COORD_W-2:0], ge};
		ceil_n    = acc_n + {{(COORD_W-1){1'b0}}, (rem_n != '0)};
		skip_n    = (rem_n == '0) ? '0 : FACTOR_W'(desc_q.factor - rem_n);
		last_step = step_q == STEP_W'(COORD_W-1);
		w_dvd     = (fw_q >= {{(COORD_W-FACTOR_W){1'b0}}, desc_q.skip_cols}) ?
			COORD_W'(fw_q - {{(COORD_W-FACTOR_W){1'b0}}, desc_q.skip_cols}) : '0;
		h_dvd     = (fh_q >= {{(COORD_W-FACTOR_W){1'b0}}, desc_q.skip_rows}) ?
			COORD_W'(fh_q - {{(COORD_W-FACTOR_W){1'b0}}, desc_q.skip_rows}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			sf_q             <= FACTOR_W'(1);
			left_q           <= '0;
			top_q            <= '0;
			fw_q             <= '0;
			fh_q             <= '0;
			sw_q             <= COORD_W'(1);
			sh_q             <= COORD_W'(1);
			acc_q            <= '0;
			rem_q            <= '0;
			step_q           <= '0;
			desc_q           <= '{factor: FACTOR_W'(1), default: '0};
		end else if (cfg_valid) begin
			state_q <= S_START;
			unique case (cfg_index)
				REG_SAMPLE_FACTOR: sf_q   <= cfg_data[FACTOR_W-1:0];
				REG_FRAME_LEFT:    left_q <= cfg_data;
				REG_FRAME_TOP:     top_q  <= cfg_data;
				REG_FRAME_WIDTH:   fw_q   <= cfg_data;
				REG_FRAME_HEIGHT:  fh_q   <= cfg_data;
				REG_SCREEN_WIDTH:  sw_q   <= cfg_data;
				REG_SCREEN_HEIGHT: sh_q   <= cfg_data;
				default: begin
				end
			endcase
		end else begin
			unique case (state_q)
				S_IDLE: begin
				end
				S_START: begin
					desc_q.factor <= f_clamp;
					desc_q.fw     <= fw_q;
					desc_q.fh     <= fh_q;
					acc_q         <= left_q;
					rem_q         <= '0;
					step_q        <= '0;
					state_q       <= S_LEFT;
				end
				S_LEFT, S_TOP, S_WIDTH, S_HEIGHT: begin
					if (!last_step) begin
						acc_q  <= acc_n;
						rem_q  <= rem_n;
						step_q <= step_q + STEP_W'(1);
					end else begin
						rem_q  <= '0;
						step_q <= '0;
						unique case (state_q)
							S_LEFT: begin
								desc_q.left      <= ceil_n;
								desc_q.skip_cols <= skip_n;
								acc_q            <= top_q;
								state_q          <= S_TOP;
							end
							S_TOP: begin
								desc_q.top       <= ceil_n;
								desc_q.skip_rows <= skip_n;
								acc_q            <= w_dvd;
								state_q          <= S_WIDTH;
							end
							S_WIDTH: begin
								desc_q.ow <= acc_n;
								acc_q     <= h_dvd;
								state_q   <= S_HEIGHT;
							end
							default: begin
								desc_q.oh <= acc_n;
								if (desc_q.ow == '0 || acc_n == '0) begin
									desc_q.left <= '0;
									desc_q.top  <= '0;
								end
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = state_q != S_IDLE;
	assign desc      = desc_q;

endmodule

`default_nettype wire

FILE: src/gafd_front.sv
`default_nettype none

module gafd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gafd_pkg::PIX_W-1:0]   pixel_value,
	input  logic                         busy,
	input  gafd_pkg::frame_desc_t        desc,
	input  logic                         q_full,
	output logic                         push,
	output gafd_pkg::out_item_t          item
);
	import gafd_pkg::*;

	logic [COORD_W-1:0]  ic_q;
	logic [COORD_W-1:0]  ir_q;
	logic [FACTOR_W-1:0] cp_q;
	logic [FACTOR_W-1:0] rp_q;
	logic [COORD_W-1:0]  ec_q;
	logic [COORD_W-1:0]  er_q;
	frame_desc_t         lat_q;

	logic                frame_start;
	frame_desc_t         d;
	logic [FACTOR_W-1:0] cp;
	logic [FACTOR_W-1:0] rp;
	logic [COORD_W-1:0]  ec;
	logic [COORD_W-1:0]  er;
	logic                nonempty;
	logic                keep;
	logic                accept;
	logic [COORD_W-1:0]  ic_n;
	logic [COORD_W-1:0]  ir_n;
	logic [FACTOR_W-1:0] cp_n;
	logic [FACTOR_W-1:0] rp_n;
	logic [COORD_W-1:0]  ec_n;
	logic [COORD_W-1:0]  er_n;

	// The first pixel of a frame takes the descriptor worked out at set-up.
	always_comb begin
		frame_start = (ic_q == '0) && (ir_q == '0);
		d           = frame_start ? desc : lat_q;
		cp          = frame_start ? desc.skip_cols : cp_q;
		rp          = frame_start ? desc.skip_rows : rp_q;
		ec          = frame_start ? '0 : ec_q;
		er          = frame_start ? '0 : er_q;
		nonempty    = (d.fw != '0) && (d.fh != '0);
		keep        = nonempty && (cp == '0) && (rp == '0) && (ec < d.ow) && (er < d.oh);
		in_ready    = !busy && !q_full;
		accept      = in_valid && in_ready;
		push        = accept && keep;

		item.pixel  = pixel_value;
		item.col    = ec;
		item.row    = er;
		item.last   = ({1'b0, ec} + 17'd1 == {1'b0, d.ow}) &&
			({1'b0, er} + 17'd1 == {1'b0, d.oh});
		item.left   = d.left;
		item.top    = d.top;
		item.width  = d.ow;
		item.height = d.oh;
	end

	always_comb begin
		ic_n = ic_q;
		ir_n = ir_q;
		rp_n = rp;
		er_n = er;
		if (cp == '0) begin
			ec_n = (ec < d.ow) ? ec + COORD_W'(1) : ec;
			cp_n = d.factor - FACTOR_W'(1);
		end else begin
			ec_n = ec;
			cp_n = cp - FACTOR_W'(1);
		end
		if ({1'b0, ic_q} + 17'd1 >= {1'b0, d.fw}) begin
			ic_n = '0;
			cp_n = d.skip_cols;
			ec_n = '0;
			if (rp == '0) begin
				er_n = (er < d.oh) ? er + COORD_W'(1) : er;
				rp_n = d.factor - FACTOR_W'(1);
			end else begin
				rp_n = rp - FACTOR_W'(1);
			end
			if ({1'b0, ir_q} + 17'd1 >= {1'b0, d.fh}) begin
				ir_n = '0;
				cp_n = '0;
				rp_n = '0;
				er_n = '0;
			end else begin
				ir_n = ir_q + COORD_W'(1);
			end
		end else begin
			ic_n = ic_q + COORD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q  <= '0;
			ir_q  <= '0;
			cp_q  <= '0;
			rp_q  <= '0;
			ec_q  <= '0;
			er_q  <= '0;
			lat_q <= '0;
		end else if (accept) begin
			lat_q <= d;
			if (nonempty) begin
				ic_q <= ic_n;
				ir_q <= ir_n;
				cp_q <= cp_n;
				rp_q <= rp_n;
				ec_q <= ec_n;
				er_q <= er_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/gafd_queue.sv
`default_nettype none

module gafd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  gafd_pkg::out_item_t    wr_item,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_ready,
	output gafd_pkg::out_item_t    rd_item
);
	import gafd_pkg::*;

	out_item_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     cnt_q;
	logic                 pop;

	assign full      = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/grid_aligned_frame_decimator.sv
// A kept pixel is registered into a four-entry queue when accepted, so the output can stall on its own.
// Throughput: one pixel per clock unless set-up is busy or the queue is full.
// A configuration write restarts set-up: one shared divider runs four 16-step divisions,
// so the pixel input is held off until all four are done.
// Reset returns the registers to their reset values, clears all counters and the queue.
`default_nettype none

module grid_aligned_frame_decimator #(
	parameter int MAX_FACTOR = gafd_pkg::DEF_MAX_FACTOR
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gafd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gafd_pkg::COORD_W-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [gafd_pkg::PIX_W-1:0]       pixel_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gafd_pkg::PIX_W-1:0]       kept_pixel,
	output logic [gafd_pkg::COORD_W-1:0]     out_col,
	output logic [gafd_pkg::COORD_W-1:0]     out_row,
	output logic                             last_of_frame,
	output logic [gafd_pkg::COORD_W-1:0]     out_left,
	output logic [gafd_pkg::COORD_W-1:0]     out_top,
	output logic [gafd_pkg::COORD_W-1:0]     out_width,
	output logic [gafd_pkg::COORD_W-1:0]     out_height
);
	import gafd_pkg::*;

	logic        busy;
	frame_desc_t desc;
	logic        q_full;
	logic        push;
	out_item_t   wr_item;
	out_item_t   rd_item;

	gafd_setup #(
		.MAX_FACTOR(MAX_FACTOR)
	) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.busy     (busy),
		.desc     (desc)
	);

	gafd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_value(pixel_value),
		.busy       (busy),
		.desc       (desc),
		.q_full     (q_full),
		.push       (push),
		.item       (wr_item)
	);

	gafd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.full     (q_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rd_item  (rd_item)
	);

	assign kept_pixel    = rd_item.pixel;
	assign out_col       = rd_item.col;
	assign out_row       = rd_item.row;
	assign last_of_frame = rd_item.last;
	assign out_left      = rd_item.left;
	assign out_top       = rd_item.top;
	assign out_width     = rd_item.width;
	assign out_height    = rd_item.height;

endmodule

`default_nettype wire

FILE: tb/grid_aligned_frame_decimator_test.sv
`timescale 1ns / 100ps

module grid_aligned_frame_decimator_test;
	import gafd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_ITEMS   = 1600;
	localparam int DIR_ROWS     = 31;

	typedef enum bit {ROW_CFG, ROW_PIX} row_kind_e;

	typedef struct {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [COORD_W-1:0]   data;
		logic [PIX_W-1:0]     pix;
		bit                   typed;
		bit                   hit;
		out_item_t            want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIX_W-1:0]     kept_pixel;
	logic [COORD_W-1:0]   out_col;
	logic [COORD_W-1:0]   out_row;
	logic                 last_of_frame;
	logic [COORD_W-1:0]   out_left;
	logic [COORD_W-1:0]   out_top;
	logic [COORD_W-1:0]   out_width;
	logic [COORD_W-1:0]   out_height;

	grid_aligned_frame_decimator uut (.*);

	// Register mirror.
	logic [FACTOR_W-1:0] cfg_factor = 1;
	logic [COORD_W-1:0]  cfg_left   = 0;
	logic [COORD_W-1:0]  cfg_top    = 0;
	logic [COORD_W-1:0]  cfg_fw     = 0;
	logic [COORD_W-1:0]  cfg_fh     = 0;
	logic [COORD_W-1:0]  cfg_sw     = 1;
	logic [COORD_W-1:0]  cfg_sh     = 1;

	// Decimator model state; the cur_ and skip_ values are latched at the first pixel of a frame.
	logic [COORD_W-1:0]  col_cnt    = 0;
	logic [COORD_W-1:0]  row_cnt    = 0;
	logic [FACTOR_W-1:0] col_ph     = 0;
	logic [FACTOR_W-1:0] row_ph     = 0;
	logic [COORD_W-1:0]  emit_col   = 0;
	logic [COORD_W-1:0]  emit_row   = 0;
	logic [FACTOR_W-1:0] skip_c     = 0;
	logic [FACTOR_W-1:0] skip_r     = 0;
	logic [FACTOR_W-1:0] cur_factor = 1;
	logic [COORD_W-1:0]  cur_fw     = 0;
	logic [COORD_W-1:0]  cur_fh     = 0;
	logic [COORD_W-1:0]  cur_left   = 0;
	logic [COORD_W-1:0]  cur_top    = 0;
	logic [COORD_W-1:0]  cur_ow     = 0;
	logic [COORD_W-1:0]  cur_oh     = 0;

	out_item_t expected_q[$];
	int        mismatches     = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        cycle_count    = 0;

	stim_row_t dir_tab [DIR_ROWS] = '{
		'{ROW_PIX, REG_NONE, 16'h0000, 8'hFF, 1'b1, 1'b0, '0},
		'{ROW_CFG, REG_NONE, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h00, 1'b1, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_WIDTH, 16'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 16'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_SAMPLE_FACTOR, 16'd0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h00, 1'b1, 1'b1,
			'{8'h00, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd2, 16'd2}},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'hFF, 1'b1, 1'b1,
			'{8'hFF, 16'd1, 16'd0, 1'b0, 16'd0, 16'd0, 16'd2, 16'd2}},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'hA5, 1'b1, 1'b1,
			'{8'hA5, 16'd0, 16'd1, 1'b0, 16'd0, 16'd0, 16'd2, 16'd2}},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h5A, 1'b1, 1'b1,
			'{8'h5A, 16'd1, 16'd1, 1'b1, 16'd0, 16'd0, 16'd2, 16'd2}},
		'{ROW_CFG, REG_SCREEN_WIDTH, 16'd0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_LEFT, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_TOP, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_WIDTH, 16'd1, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 16'd1, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_SAMPLE_FACTOR, 16'h00FF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h3C, 1'b1, 1'b1,
			'{8'h3C, 16'd0, 16'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1}},
		'{ROW_CFG, REG_SCREEN_WIDTH, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_SCREEN_HEIGHT, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'hC3, 1'b1, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_WIDTH, 16'd3, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 16'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_SAMPLE_FACTOR, 16'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_LEFT, 16'd1, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_FRAME_TOP, 16'd0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h81, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h7E, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h01, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h80, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'hFE, 1'b0, 1'b0, '0},
		'{ROW_PIX, REG_NONE, 16'h0000, 8'h7F, 1'b0, 1'b0, '0}
	};

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [COORD_W-1:0] data);
		case (idx)
			REG_SAMPLE_FACTOR: cfg_factor = data[FACTOR_W-1:0];
			REG_FRAME_LEFT:    cfg_left   = data;
			REG_FRAME_TOP:     cfg_top    = data;
			REG_FRAME_WIDTH:   cfg_fw     = data;
			REG_FRAME_HEIGHT:  cfg_fh     = data;
			REG_SCREEN_WIDTH:  cfg_sw     = data;
			REG_SCREEN_HEIGHT: cfg_sh     = data;
			default: ;
		endcase
	endfunction

	function automatic void start_frame();
		int unsigned f, m, offx, offy, sc, sr, ow, oh;
		f = 32'(cfg_factor);
		m = 32'((cfg_sw < cfg_sh) ? cfg_sw : cfg_sh);
		if (f == 0) f = 1;
		if (f > DEF_MAX_FACTOR) f = DEF_MAX_FACTOR;
		if (m == 0) m = 1;
		if (f > m) f = m;
		offx = (32'(cfg_left) + f - 1) / f;
		offy = (32'(cfg_top) + f - 1) / f;
		sc = offx * f - 32'(cfg_left);
		sr = offy * f - 32'(cfg_top);
		ow = (32'(cfg_fw) >= sc) ? (32'(cfg_fw) - sc) / f : 0;
		oh = (32'(cfg_fh) >= sr) ? (32'(cfg_fh) - sr) / f : 0;
		if (ow == 0 || oh == 0) begin
			offx = 0;
			offy = 0;
		end
		cur_factor = FACTOR_W'(f);
		cur_fw     = cfg_fw;
		cur_fh     = cfg_fh;
		skip_c     = FACTOR_W'(sc);
		skip_r     = FACTOR_W'(sr);
		cur_ow     = COORD_W'(ow);
		cur_oh     = COORD_W'(oh);
		cur_left   = COORD_W'(offx);
		cur_top    = COORD_W'(offy);
		col_ph     = FACTOR_W'(sc);
		row_ph     = FACTOR_W'(sr);
		emit_col   = '0;
		emit_row   = '0;
	endfunction

	function automatic void decimate_pixel(input logic [PIX_W-1:0] pix, output bit kept,
			output out_item_t res);
		kept = 1'b0;
		res  = '0;
		if (col_cnt == '0 && row_cnt == '0)
			start_frame();
		if (cur_fw == '0 || cur_fh == '0)
			return;
		if (col_ph == '0 && row_ph == '0 && emit_col < cur_ow && emit_row < cur_oh) begin
			kept       = 1'b1;
			res.pixel  = pix;
			res.col    = emit_col;
			res.row    = emit_row;
			res.last   = (32'(emit_col) + 1 == 32'(cur_ow)) &&
				(32'(emit_row) + 1 == 32'(cur_oh));
			res.left   = cur_left;
			res.top    = cur_top;
			res.width  = cur_ow;
			res.height = cur_oh;
		end
		if (col_ph == '0) begin
			if (emit_col < cur_ow) emit_col++;
			col_ph = cur_factor - FACTOR_W'(1);
		end else begin
			col_ph--;
		end
		if (32'(col_cnt) + 1 >= 32'(cur_fw)) begin
			col_cnt  = '0;
			col_ph   = skip_c;
			emit_col = '0;
			if (row_ph == '0) begin
				if (emit_row < cur_oh) emit_row++;
				row_ph = cur_factor - FACTOR_W'(1);
			end else begin
				row_ph--;
			end
			if (32'(row_cnt) + 1 >= 32'(cur_fh)) begin
				row_cnt  = '0;
				col_ph   = '0;
				row_ph   = '0;
				emit_row = '0;
			end else begin
				row_cnt++;
			end
		end else begin
			col_cnt++;
		end
	endfunction

	// All driving tasks start and end just after a falling edge.
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed, input bit hit,
			input out_item_t want);
		bit        kept;
		out_item_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		pixel_value = pix;
		do @(posedge clk); while (!in_ready);
		decimate_pixel(pix, kept, res);
		if (typed) begin
			if (hit) expected_q.push_back(want);
		end else if (kept) begin
			expected_q.push_back(res);
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 199) == 0)
				while (expected_q.size() != 0) @(negedge clk);
			send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : check_out
		out_item_t got;
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kept_pixel, out_col, out_row, last_of_frame, out_left, out_top,
				out_width, out_height};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel: pix %h col %0d row %0d last %b",
						got.pixel, got.col, got.row, got.last);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected pix %h col %0d row %0d last %b ",
							"left %0d top %0d w %0d h %0d, got pix %h col %0d row %0d ",
							"last %b left %0d top %0d w %0d h %0d"},
							want.pixel, want.col, want.row, want.last, want.left,
							want.top, want.width, want.height, got.pixel, got.col,
							got.row, got.last, got.left, got.top, got.width, got.height);
				end
			end
		end
	end

	initial begin
		int               seg;
		int               rand_items;
		int               n;
		int               frame_px;
		bit               big;
		logic [COORD_W-1:0] v_factor, v_left, v_top, v_fw, v_fh, v_sw, v_sh;

		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_value = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct  = 19;
		recv_stall_pct = 19;
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_tab[r].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_tab[r].idx, dir_tab[r].data);
			end else begin
				send_pixel(dir_tab[r].pix, dir_tab[r].typed, dir_tab[r].hit, dir_tab[r].want);
			end
		end

		seg        = 0;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			big = (seg == 0 || seg == 4);
			if (big) begin
				v_factor = 16'd255;
				v_sw     = 16'hFFFF;
				v_sh     = 16'hFFFF;
				v_fw     = (seg == 0) ? 16'd300 : 16'd1;
				v_fh     = (seg == 0) ? 16'd1 : 16'd300;
			end else begin
				case ($urandom_range(0, 7))
					0: v_factor = COORD_W'($urandom_range(0, 255));
					1: v_factor = COORD_W'($urandom_range(0, 65535));
					default: v_factor = COORD_W'($urandom_range(1, 4));
				endcase
				v_sw = COORD_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) :
					$urandom_range(1, 65535));
				v_sh = COORD_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) :
					$urandom_range(1, 65535));
				v_fw = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
				v_fh = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
			end
			v_left = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 65535) :
				$urandom_range(0, 8));
			v_top  = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 65535) :
				$urandom_range(0, 8));

			wait_drained();
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_NONE, COORD_W'($urandom_range(0, 65535)));
			write_reg(REG_SAMPLE_FACTOR, v_factor);
			write_reg(REG_FRAME_LEFT, v_left);
			write_reg(REG_FRAME_TOP, v_top);
			write_reg(REG_FRAME_WIDTH, v_fw);
			write_reg(REG_FRAME_HEIGHT, v_fh);
			write_reg(REG_SCREEN_WIDTH, v_sw);
			write_reg(REG_SCREEN_HEIGHT, v_sh);

			// A frame left unfinished keeps its old settings until its last pixel.
			n = 0;
			if (col_cnt != '0 || row_cnt != '0)
				n = int'(cur_fw) * int'(cur_fh) - (int'(row_cnt) * int'(cur_fw) + int'(col_cnt));
			frame_px = int'(v_fw) * int'(v_fh);
			n += frame_px * (big ? 1 : int'($urandom_range(1, 3)));
			if (!big && frame_px > 1 && $urandom_range(0, 7) == 0)
				n += int'($urandom_range(1, frame_px - 1));
			send_random_pixels(n);
			rand_items += n;
			if (frame_px == 0)
				send_random_pixels(int'($urandom_range(1, 3)));
			seg++;
		end

		while (expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/gafd_pkg.sv
src/gafd_setup.sv
src/gafd_front.sv
src/gafd_queue.sv
src/grid_aligned_frame_decimator.sv
tb/grid_aligned_frame_decimator_test.sv
